// ===== hdl/llti_pkg.sv =====
// ----------------------------------------------------------------------------
// llti_pkg
// Shared widths, codes and elaboration-time helpers for the log-linear
// table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package llti_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int HEIGHT_W  = 27;
    localparam int VALUE_W   = 31;
    localparam int COUNT_W   = 7;
    localparam int SLOT_W    = 6;
    localparam int FRAC_W    = 30;
    localparam int LOG_W     = 36;
    localparam int MAG_W     = 35;
    localparam int POS_W     = 5;
    localparam int SHIFT_W   = 7;

    localparam int LOG_LAT   = 32;
    localparam int EXP_LAT   = 32;
    localparam int DIV_STEPS = MAG_W;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [1:0] region_t;

    localparam region_t REGION_BELOW  = 2'd0;
    localparam region_t REGION_INSIDE = 2'd1;
    localparam region_t REGION_ABOVE  = 2'd2;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_w;
        rem   = x;
        root  = '0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bit_w > rem)
            begin
                bit_w = bit_w >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bit_w != '0)
            begin
                if (rem >= root + bit_w)
                begin
                    rem  = rem - (root + bit_w);
                    root = (root >> 1) + bit_w;
                end
                else
                begin
                    root = root >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return root;
    endfunction

    // Coefficient for fraction bit (FRAC_W-1-step): repeated square roots of sqrt(2)
    function automatic logic [VALUE_W-1:0] exp_coef(input int step);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int i = 0; i < FRAC_W; i++)
        begin
            if (i < step)
            begin
                c = isqrt64(c << 30);
            end
        end
        return c[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/llti_log2.sv =====
// ----------------------------------------------------------------------------
// llti_log2
// Pipelined log2 of an unsigned Q1.30 value: normalize over two stages,
// then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module llti_log2
    import llti_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [VALUE_W-1:0]      value,
    output logic signed [LOG_W-1:0] log_value
);

    localparam int SQ_STEPS = FRAC_W;
    localparam int INT_W    = LOG_W - FRAC_W;

    logic [VALUE_W-1:0] val_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic [VALUE_W-1:0] man_reg  [SQ_STEPS+1];
    logic [POS_W-1:0]   mpos_reg [SQ_STEPS+1];
    logic [FRAC_W-1:0]  frac_reg [SQ_STEPS+1];

    always_comb
    begin
        pos_next = '0;
        for (int i = 1; i < VALUE_W; i++)
        begin
            if (value[i])
            begin
                pos_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg     <= value;
            pos_reg     <= pos_next;
            man_reg[0]  <= val_reg << (POS_W'(FRAC_W) - pos_reg);
            mpos_reg[0] <= pos_reg;
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic [2*VALUE_W-1:0] sq;
        logic [VALUE_W:0]     sq_top;

        assign sq     = man_reg[k] * man_reg[k];
        assign sq_top = sq[2*VALUE_W-1:FRAC_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mpos_reg[k+1] <= mpos_reg[k];
                if (sq_top[VALUE_W])
                begin
                    man_reg[k+1]  <= sq_top[VALUE_W:1];
                    frac_reg[k+1] <= {frac_reg[k][FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    man_reg[k+1]  <= sq_top[VALUE_W-1:0];
                    frac_reg[k+1] <= {frac_reg[k][FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    assign log_value = {INT_W'(mpos_reg[SQ_STEPS]) - INT_W'(FRAC_W), frac_reg[SQ_STEPS]};

endmodule

`default_nettype wire

// ===== hdl/llti_exp2.sv =====
// ----------------------------------------------------------------------------
// llti_exp2
// Pipelined exp2 of a signed log value with 30 fraction bits, giving an
// unsigned Q1.30 result clamped to 31 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module llti_exp2
    import llti_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [LOG_W-1:0] log_value,
    output logic [VALUE_W-1:0]      value
);

    localparam int RW = VALUE_W + 1;

    logic [LOG_W-1:0]   mag_next;
    logic               sat_next;
    logic [SHIFT_W-1:0] shift_next;
    logic [FRAC_W-1:0]  f_next;

    logic               sat_reg   [FRAC_W+1];
    logic [SHIFT_W-1:0] shift_reg [FRAC_W+1];
    logic [FRAC_W-1:0]  f_reg     [FRAC_W+1];
    logic [RW-1:0]      r_reg     [FRAC_W+1];

    logic [RW-1:0]      shifted;
    logic [VALUE_W-1:0] value_next;
    logic [VALUE_W-1:0] value_reg;

    always_comb
    begin
        mag_next   = -log_value;
        sat_next   = 1'b0;
        shift_next = '0;
        f_next     = '0;
        if (!log_value[LOG_W-1])
        begin
            sat_next = (log_value[LOG_W-2:FRAC_W] != '0);
            f_next   = log_value[FRAC_W-1:0];
        end
        else if (mag_next[FRAC_W-1:0] != '0)
        begin
            shift_next = SHIFT_W'(mag_next[LOG_W-1:FRAC_W]) + SHIFT_W'(1);
            f_next     = -mag_next[FRAC_W-1:0];
        end
        else
        begin
            shift_next = SHIFT_W'(mag_next[LOG_W-1:FRAC_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0]   <= sat_next;
            shift_reg[0] <= shift_next;
            f_reg[0]     <= f_next;
            r_reg[0]     <= RW'(1) << FRAC_W;
        end
    end

    for (genvar j = 0; j < FRAC_W; j++)
    begin : g_mul
        localparam logic [VALUE_W-1:0] COEF = exp_coef(j);

        logic [RW+VALUE_W-1:0] prod;

        assign prod = r_reg[j] * COEF;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[j+1]   <= sat_reg[j];
                shift_reg[j+1] <= shift_reg[j];
                f_reg[j+1]     <= f_reg[j];
                if (f_reg[j][FRAC_W-1-j])
                begin
                    r_reg[j+1] <= prod[FRAC_W+RW-1:FRAC_W];
                end
                else
                begin
                    r_reg[j+1] <= r_reg[j];
                end
            end
        end
    end

    always_comb
    begin
        shifted = r_reg[FRAC_W] >> shift_reg[FRAC_W];
        if (sat_reg[FRAC_W])
        begin
            value_next = VALUE_MAX;
        end
        else if (shift_reg[FRAC_W] > SHIFT_W'(RW - 1))
        begin
            value_next = '0;
        end
        else if (shifted > RW'(VALUE_MAX))
        begin
            value_next = VALUE_MAX;
        end
        else
        begin
            value_next = shifted[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/log_linear_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// log_linear_table_interpolator
// Sorted height table with geometric interpolation of the stored index.
//
//   channel  dir  handshake                  payload
//   input    in   in_valid / in_stall        operation, entry_slot,
//                                            entry_height, entry_value,
//                                            query_altitude
//   result   out  out_valid / out_stall      interpolated_value, region
//   config   in   cfg_write_en               cfg_write_data (entry_count)
//
// One query enters per cycle while the input is not stalled; its result passes
// through the log2 squaring chain, the 35-step divider and the exp2 multiply chain.
// A load waits until the four search stages ahead of the table read drain.
// Reset clears the valid bits and sets entry_count to 2; the table needs no clearing.
// A held result freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module log_linear_table_interpolator
    import llti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [SLOT_W-1:0]   entry_slot,
    input  logic [HEIGHT_W-1:0] entry_height,
    input  logic [VALUE_W-1:0]  entry_value,
    input  logic [HEIGHT_W-1:0] query_altitude,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [VALUE_W-1:0]  interpolated_value,
    output logic [1:0]          region,

    input  logic                cfg_write_en,
    input  logic [COUNT_W-1:0]  cfg_write_data
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW      = $clog2(TABLE_DEPTH + 1);
    localparam int CW      = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int GRP_W   = 32;
    localparam int GI_W    = $clog2(GRP_W);
    localparam int NG      = (TABLE_DEPTH + GRP_W - 1) / GRP_W;
    localparam int ENTRY_W = HEIGHT_W + VALUE_W;
    localparam int LO_W    = 18;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int PROD_W  = MAG_W + HEIGHT_W;
    localparam int NV      = 6 + LOG_LAT + 3 + DIV_STEPS + 1 + EXP_LAT;

    typedef struct packed {
        logic [HEIGHT_W-1:0] delta;
        logic [HEIGHT_W-1:0] span;
        logic                direct;
        logic [VALUE_W-1:0]  dval;
        region_t             zone;
    } lsb_t;

    typedef struct packed {
        logic                    neg;
        logic signed [LOG_W-1:0] base;
        logic [HEIGHT_W-1:0]     span;
        logic                    direct;
        logic [VALUE_W-1:0]      dval;
        region_t                 zone;
    } dsb_t;

    typedef struct packed {
        logic               direct;
        logic [VALUE_W-1:0] dval;
        region_t            zone;
    } osb_t;

    // control
    logic                en;
    logic                busy;
    logic                in_take;
    logic                q_take;
    logic                ld_take;
    logic                load_wr;
    logic [31:0]         slot_wide;
    logic [IDX_W-1:0]    wr_addr;
    logic [NV-1:0]       vld_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [CW-1:0]       count_ext;
    logic [NW-1:0]       n_w;

    // table
    logic [HEIGHT_W-1:0] height_reg [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  tbl_mem    [TABLE_DEPTH];

    // search
    logic [HEIGHT_W-1:0] alt_s0_reg;
    logic [NG*GRP_W-1:0] gt_next;
    logic [NG*GRP_W-1:0] gt_reg;
    logic [HEIGHT_W-1:0] alt_s1_reg;
    logic [NG-1:0]       grp_any_next;
    logic [GI_W-1:0]     grp_idx_next [NG];
    logic [NG-1:0]       grp_any_reg;
    logic [GI_W-1:0]     grp_idx_reg  [NG];
    logic [HEIGHT_W-1:0] alt_s2_reg;
    logic [NW-1:0]       up_next;
    region_t             region_next;
    logic [NW-1:0]       up_s3_reg;
    region_t             region_s3_reg;
    logic [HEIGHT_W-1:0] alt_s3_reg;
    logic [NW-1:0]       up_m1;
    logic [NW-1:0]       n_m1;
    logic [IDX_W-1:0]    addr_a;
    logic [IDX_W-1:0]    addr_b;
    logic [ENTRY_W-1:0]  rda_reg;
    logic [ENTRY_W-1:0]  rdb_reg;
    logic [HEIGHT_W-1:0] alt_s4_reg;
    region_t             region_s4_reg;

    // prep
    logic [HEIGHT_W-1:0] ha;
    logic [HEIGHT_W-1:0] hb;
    logic [VALUE_W-1:0]  va;
    logic [VALUE_W-1:0]  vb;
    lsb_t                s5_next;
    lsb_t                s5_reg;
    logic [VALUE_W-1:0]  va_s5_reg;
    logic [VALUE_W-1:0]  vb_s5_reg;
    lsb_t                lsb_reg [LOG_LAT];

    // blend
    logic signed [LOG_W-1:0] log_lo;
    logic signed [LOG_W-1:0] log_hi;
    logic signed [LOG_W-1:0] diff;
    logic [LOG_W-1:0]        mag_wide;
    dsb_t                    d0_next;
    dsb_t                    d0_reg;
    logic [MAG_W-1:0]        mag_d0_reg;
    logic [HEIGHT_W-1:0]     delta_d0_reg;
    dsb_t                    d1_reg;
    logic [LO_W+HEIGHT_W-1:0] pl_reg;
    logic [HI_W+HEIGHT_W-1:0] ph_reg;
    logic [PROD_W-1:0]       prod;

    // divide
    logic [HEIGHT_W-1:0] rem_reg [DIV_STEPS+1];
    logic [MAG_W-1:0]    num_reg [DIV_STEPS+1];
    logic [MAG_W-1:0]    quo_reg [DIV_STEPS+1];
    dsb_t                dsb_reg [DIV_STEPS+1];

    // exp
    logic signed [LOG_W-1:0] lsum_next;
    logic signed [LOG_W-1:0] lsum_reg;
    osb_t                    osb_ls_reg;
    osb_t                    osb_reg [EXP_LAT];
    logic [VALUE_W-1:0]      exp_value;
    logic [VALUE_W-1:0]      out_value_reg;
    region_t                 out_region_reg;

    // ------------------------------------------------------------------
    // handshake and configuration
    // ------------------------------------------------------------------
    assign en        = !out_valid_reg || !out_stall;
    assign busy      = vld_reg[0] || vld_reg[1] || vld_reg[2] || vld_reg[3];
    assign in_stall  = !en || ((operation == OP_LOAD) && busy);
    assign in_take   = in_valid && !in_stall;
    assign q_take    = in_take && (operation == OP_QUERY);
    assign ld_take   = in_take && (operation == OP_LOAD);
    assign slot_wide = 32'(entry_slot);
    assign wr_addr   = slot_wide[IDX_W-1:0];
    assign load_wr   = ld_take && (slot_wide < 32'(TABLE_DEPTH));

    always_comb
    begin
        count_ext = CW'(count_reg);
        if (count_ext < CW'(2))
        begin
            n_w = NW'(2);
        end
        else if (count_ext > CW'(TABLE_DEPTH))
        begin
            n_w = NW'(TABLE_DEPTH);
        end
        else
        begin
            n_w = NW'(count_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
            if (en)
            begin
                vld_reg       <= {vld_reg[NV-2:0], q_take};
                out_valid_reg <= vld_reg[NV-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // table store
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            height_reg[wr_addr] <= entry_height;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            tbl_mem[wr_addr] <= {entry_height, entry_value};
        end
        if (en)
        begin
            rda_reg <= tbl_mem[addr_a];
            rdb_reg <= tbl_mem[addr_b];
        end
    end

    // ------------------------------------------------------------------
    // search
    // ------------------------------------------------------------------
    always_comb
    begin
        gt_next = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            gt_next[i] = (height_reg[i] > alt_s0_reg) && (NW'(i) < n_w);
        end
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |gt_reg[g*GRP_W +: GRP_W];
            grp_idx_next[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--)
            begin
                if (gt_reg[g*GRP_W + b])
                begin
                    grp_idx_next[g] = GI_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        up_next = n_w;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                up_next = NW'(g*GRP_W + int'(grp_idx_reg[g]));
            end
        end
        if (up_next == '0)
        begin
            region_next = REGION_BELOW;
        end
        else if (up_next == n_w)
        begin
            region_next = REGION_ABOVE;
        end
        else
        begin
            region_next = REGION_INSIDE;
        end
    end

    assign up_m1 = up_s3_reg - NW'(1);
    assign n_m1  = n_w - NW'(1);

    always_comb
    begin
        case (region_s3_reg)
            REGION_BELOW:
            begin
                addr_a = '0;
            end
            REGION_ABOVE:
            begin
                addr_a = n_m1[IDX_W-1:0];
            end
            default:
            begin
                addr_a = up_m1[IDX_W-1:0];
            end
        endcase
        addr_b = (region_s3_reg == REGION_INSIDE) ? up_s3_reg[IDX_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_s0_reg    <= query_altitude;
            gt_reg        <= gt_next;
            alt_s1_reg    <= alt_s0_reg;
            grp_any_reg   <= grp_any_next;
            grp_idx_reg   <= grp_idx_next;
            alt_s2_reg    <= alt_s1_reg;
            up_s3_reg     <= up_next;
            region_s3_reg <= region_next;
            alt_s3_reg    <= alt_s2_reg;
            alt_s4_reg    <= alt_s3_reg;
            region_s4_reg <= region_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // neighbor prep and log2
    // ------------------------------------------------------------------
    assign ha = rda_reg[ENTRY_W-1:VALUE_W];
    assign va = rda_reg[VALUE_W-1:0];
    assign hb = rdb_reg[ENTRY_W-1:VALUE_W];
    assign vb = rdb_reg[VALUE_W-1:0];

    always_comb
    begin
        s5_next.delta  = alt_s4_reg - ha;
        s5_next.span   = hb - ha;
        s5_next.zone   = region_s4_reg;
        s5_next.direct = (region_s4_reg != REGION_INSIDE) || (s5_next.delta == '0)
                         || (va == '0) || (vb == '0);
        s5_next.dval   = ((region_s4_reg == REGION_INSIDE) && (s5_next.delta != '0))
                         ? '0 : va;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg     <= s5_next;
            va_s5_reg  <= va;
            vb_s5_reg  <= vb;
            lsb_reg[0] <= s5_reg;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                lsb_reg[i] <= lsb_reg[i-1];
            end
        end
    end

    llti_log2 u_log_lo
    (
        .clk       (clk),
        .en        (en),
        .value     (va_s5_reg),
        .log_value (log_lo)
    );

    llti_log2 u_log_hi
    (
        .clk       (clk),
        .en        (en),
        .value     (vb_s5_reg),
        .log_value (log_hi)
    );

    // ------------------------------------------------------------------
    // weighted offset: |Lb-La| * delta / span
    // ------------------------------------------------------------------
    always_comb
    begin
        diff           = log_hi - log_lo;
        mag_wide       = diff[LOG_W-1] ? -diff : diff;
        d0_next.neg    = diff[LOG_W-1];
        d0_next.base   = log_lo;
        d0_next.span   = lsb_reg[LOG_LAT-1].span;
        d0_next.direct = lsb_reg[LOG_LAT-1].direct;
        d0_next.dval   = lsb_reg[LOG_LAT-1].dval;
        d0_next.zone   = lsb_reg[LOG_LAT-1].zone;
    end

    assign prod = (PROD_W'(ph_reg) << LO_W) + PROD_W'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg       <= d0_next;
            mag_d0_reg   <= mag_wide[MAG_W-1:0];
            delta_d0_reg <= lsb_reg[LOG_LAT-1].delta;
            d1_reg       <= d0_reg;
            pl_reg       <= mag_d0_reg[LO_W-1:0] * delta_d0_reg;
            ph_reg       <= mag_d0_reg[MAG_W-1:LO_W] * delta_d0_reg;
            rem_reg[0]   <= prod[PROD_W-1:MAG_W];
            num_reg[0]   <= prod[MAG_W-1:0];
            quo_reg[0]   <= '0;
            dsb_reg[0]   <= d1_reg;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [HEIGHT_W:0] trial;
        logic [HEIGHT_W:0] diff_w;
        logic              ge;

        assign trial  = {rem_reg[k], num_reg[k][MAG_W-1]};
        assign diff_w = trial - {1'b0, dsb_reg[k].span};
        assign ge     = (trial >= {1'b0, dsb_reg[k].span});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff_w[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
                num_reg[k+1] <= num_reg[k] << 1;
                quo_reg[k+1] <= {quo_reg[k][MAG_W-2:0], ge};
                dsb_reg[k+1] <= dsb_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // blend and exp2
    // ------------------------------------------------------------------
    always_comb
    begin
        if (dsb_reg[DIV_STEPS].neg)
        begin
            lsum_next = dsb_reg[DIV_STEPS].base - signed'(LOG_W'(quo_reg[DIV_STEPS]));
        end
        else
        begin
            lsum_next = dsb_reg[DIV_STEPS].base + signed'(LOG_W'(quo_reg[DIV_STEPS]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lsum_reg          <= lsum_next;
            osb_ls_reg.direct <= dsb_reg[DIV_STEPS].direct;
            osb_ls_reg.dval   <= dsb_reg[DIV_STEPS].dval;
            osb_ls_reg.zone   <= dsb_reg[DIV_STEPS].zone;
            osb_reg[0]        <= osb_ls_reg;
            for (int i = 1; i < EXP_LAT; i++)
            begin
                osb_reg[i] <= osb_reg[i-1];
            end
            out_value_reg  <= osb_reg[EXP_LAT-1].direct ? osb_reg[EXP_LAT-1].dval : exp_value;
            out_region_reg <= osb_reg[EXP_LAT-1].zone;
        end
    end

    llti_exp2 u_exp
    (
        .clk       (clk),
        .en        (en),
        .log_value (lsum_reg),
        .value     (exp_value)
    );

    assign out_valid          = out_valid_reg;
    assign interpolated_value = out_value_reg;
    assign region             = out_region_reg;

`ifndef SYNTH
    a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> vld_reg[0])
        else $error("accepted query missing from first stage");

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load_wr |-> !(vld_reg[0] || vld_reg[1] || vld_reg[2]))
        else $error("table written while a query awaits its read");

    a_inside_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && (region_s3_reg == REGION_INSIDE))
        |-> ((up_s3_reg != '0) && (up_s3_reg < n_w)))
        else $error("upper neighbor outside used entries");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(vld_reg))
        else $error("pipeline advanced while result held");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for log_linear_table_interpolator
// Loads height tables, all but one of them sorted, issues altitude queries and compares every
// result against a fixed-point geometric interpolation predictor, under
// several sender-idle and receiver-stall patterns and table sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import llti_pkg::*;

    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic [HEIGHT_W-1:0] height;
        logic [VALUE_W-1:0]  value;
        logic [HEIGHT_W-1:0] altitude;
    } txn_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        region_t            reg_code;
    } interp_t;

    localparam int LATENCY     = 110;
    localparam int CYCLE_LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [SLOT_W-1:0]   entry_slot;
    logic [HEIGHT_W-1:0] entry_height;
    logic [VALUE_W-1:0]  entry_value;
    logic [HEIGHT_W-1:0] query_altitude;
    logic                out_valid;
    logic                out_stall;
    logic [VALUE_W-1:0]  interpolated_value;
    logic [1:0]          region;
    logic                cfg_write_en;
    logic [COUNT_W-1:0]  cfg_write_data;

    txn_t    pending_txns[$];
    interp_t expected_interps[$];

    logic [HEIGHT_W-1:0] model_heights[64];
    logic [VALUE_W-1:0]  model_indices[64];
    logic [COUNT_W-1:0]  model_count;

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;

    log_linear_table_interpolator u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .entry_slot         (entry_slot),
        .entry_height       (entry_height),
        .entry_value        (entry_value),
        .query_altitude     (query_altitude),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .interpolated_value (interpolated_value),
        .region             (region),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_fixed(input logic [63:0] v);
        int          p;
        logic [63:0] m;
        longint      frac;
        p = 30;
        while (p > 0 && v[p] == 1'b0)
            p--;
        m = v << (30 - p);
        frac = 0;
        for (int k = 0; k < 30; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(p - 30) * (longint'(1) << 30) + frac;
    endfunction

    function automatic logic [VALUE_W-1:0] exp2_fixed(input longint lg);
        logic [63:0] shift;
        logic [63:0] f;
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] c;
        if (lg >= 0)
        begin
            u = lg;
            if ((u >> 30) != 0)
                return VALUE_MAX;
            shift = 0;
            f = u & 64'h3FFF_FFFF;
        end
        else
        begin
            u = -lg;
            if ((u & 64'h3FFF_FFFF) != 0)
            begin
                shift = (u >> 30) + 1;
                f = (64'd1 << 30) - (u & 64'h3FFF_FFFF);
            end
            else
            begin
                shift = u >> 30;
                f = 0;
            end
        end
        r = 64'd1 << 30;
        c = root64(64'd1 << 61);
        for (int k = 29; k >= 0; k--)
        begin
            if (f[k])
                r = (r * c) >> 30;
            c = root64(c << 30);
        end
        if (shift > 31)
            return '0;
        r = r >> shift;
        return (r > VALUE_MAX) ? VALUE_MAX : r[VALUE_W-1:0];
    endfunction

    task automatic predict_interp(input txn_t t);
        int          n;
        int          up;
        longint      la;
        longint      lb;
        longint      diff;
        longint      off;
        logic [63:0] mag;
        logic [63:0] d;
        logic [63:0] dh;
        interp_t     e;
        if (t.op == OP_LOAD)
        begin
            model_heights[t.slot] = t.height;
            model_indices[t.slot] = t.value;
            return;
        end
        n = model_count;
        if (n < 2)
            n = 2;
        if (n > 64)
            n = 64;
        up = 0;
        while (up < n && model_heights[up] <= t.altitude)
            up++;
        if (up == 0)
        begin
            e.value = model_indices[0];
            e.reg_code = REGION_BELOW;
        end
        else if (up == n)
        begin
            e.value = model_indices[n-1];
            e.reg_code = REGION_ABOVE;
        end
        else
        begin
            e.reg_code = REGION_INSIDE;
            d  = t.altitude - model_heights[up-1];
            dh = model_heights[up] - model_heights[up-1];
            if (d == 0)
                e.value = model_indices[up-1];
            else if (model_indices[up-1] == 0 || model_indices[up] == 0)
                e.value = '0;
            else
            begin
                la = log2_fixed(model_indices[up-1]);
                lb = log2_fixed(model_indices[up]);
                diff = lb - la;
                mag = (diff < 0) ? -diff : diff;
                off = (mag * d) / dh;
                e.value = exp2_fixed((diff < 0) ? la - off : la + off);
            end
        end
        expected_interps.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_interp({operation, entry_slot, entry_height, entry_value,
                                query_altitude});
            if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                txn_t t;
                t = pending_txns.pop_front();
                in_valid       <= 1'b1;
                operation      <= t.op;
                entry_slot     <= t.slot;
                entry_height   <= t.height;
                entry_value    <= t.value;
                query_altitude <= t.altitude;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_interps.size() == 0)
                    report_mismatch("unexpected result", interpolated_value, 0);
                else
                begin
                    interp_t e;
                    e = expected_interps.pop_front();
                    if (interpolated_value !== e.value)
                        report_mismatch("interpolated_value", interpolated_value, e.value);
                    if (region !== e.reg_code)
                        report_mismatch("region", region, e.reg_code);
                end
            end
            if (hold_cycles > 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[log_linear_table_interpolator] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_txns.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_interps.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] cnt);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cnt;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        model_count = cnt;
    endtask

    function automatic txn_t make_load(input int slot, input logic [HEIGHT_W-1:0] h,
                                       input logic [VALUE_W-1:0] v);
        txn_t t;
        t.op = OP_LOAD;
        t.slot = SLOT_W'(slot);
        t.height = h;
        t.value = v;
        t.altitude = HEIGHT_W'($urandom);
        return t;
    endfunction

    function automatic txn_t make_query(input logic [HEIGHT_W-1:0] alt);
        txn_t t;
        t.op = OP_QUERY;
        t.slot = SLOT_W'($urandom);
        t.height = HEIGHT_W'($urandom);
        t.value = VALUE_W'($urandom);
        t.altitude = alt;
        return t;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(5))
            0: return '0;
            1: return VALUE_MAX;
            2: return VALUE_W'($urandom_range(32'h7FFF_FFFF, 32'h2000_0000));
            3: return VALUE_W'($urandom_range(255, 1));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // fill all 64 slots with a table, ascending when sorted is set, then queue queries
    task automatic queue_table(input int used, input int queries, input bit sorted);
        logic [HEIGHT_W-1:0] h;
        logic [HEIGHT_W-1:0] top;
        int step;
        step = $urandom_range(1, 2000000 / used);
        h = HEIGHT_W'($urandom_range(step));
        for (int s = 0; s < 64; s++)
        begin
            pending_txns.push_back(make_load(s, sorted ? h : HEIGHT_W'($urandom),
                                             rand_value()));
            if (s < used)
                top = h;
            h = h + HEIGHT_W'($urandom_range(1, step));
        end
        for (int q = 0; q < queries; q++)
        begin
            case ($urandom_range(9))
                0: pending_txns.push_back(make_query(HEIGHT_W'($urandom)));
                1: pending_txns.push_back(make_query(top + HEIGHT_W'($urandom_range(2))));
                2: pending_txns.push_back(make_query('1));
                default: pending_txns.push_back(
                             make_query(HEIGHT_W'($urandom_range(top + 10))));
            endcase
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] counts[6];
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        model_count    = COUNT_RESET;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        operation      = OP_LOAD;
        entry_slot     = '0;
        entry_height   = '0;
        entry_value    = '0;
        query_altitude = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        rst_n          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset count of 2, node hits, zero index, extremes
        pending_txns.push_back(make_load(0, 27'd100, 31'h4000_0000));
        pending_txns.push_back(make_load(1, 27'd300, 31'h2000_0000));
        pending_txns.push_back(make_query(27'd0));
        pending_txns.push_back(make_query(27'd99));
        pending_txns.push_back(make_query(27'd100));
        pending_txns.push_back(make_query(27'd200));
        pending_txns.push_back(make_query(27'd299));
        pending_txns.push_back(make_query(27'd300));
        pending_txns.push_back(make_query('1));
        pending_txns.push_back(make_load(1, 27'd300, 31'd0));
        pending_txns.push_back(make_query(27'd100));
        pending_txns.push_back(make_query(27'd150));
        pending_txns.push_back(make_load(0, 27'd0, VALUE_MAX));
        pending_txns.push_back(make_load(1, '1, 31'd1));
        pending_txns.push_back(make_query(27'd0));
        pending_txns.push_back(make_query(27'd5000));
        pending_txns.push_back(make_query('1));
        pending_txns.push_back(make_load(1, '1, VALUE_MAX));
        pending_txns.push_back(make_query(27'd77777));
        pending_txns.push_back(make_load(0, 27'd10, 31'd1));
        pending_txns.push_back(make_query(27'd70000000));
        wait_drained();

        counts = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd17, 7'd65};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_count(counts[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (ph == 1)
                hold_cycles = 400;
            for (int b = 0; b < 2; b++)
                queue_table((counts[ph] < 2) ? 2 : (counts[ph] > 64) ? 64 : counts[ph],
                            77, !(ph == 4 && b == 1));
            wait_drained();
        end

        if (error_count == 0)
            $display("[log_linear_table_interpolator] OK");
        else
            $display("[log_linear_table_interpolator] ERROR");
        $finish;
    end

endmodule
